@@ hw/rtl/pdc_pkg.sv @@
`default_nettype none
package pdc_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_SQRT,
      ST_UPD,
      ST_EMA,
      ST_ANG,
      ST_CORDIC,
      ST_ROT,
      ST_OUT
   } state_type;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   localparam logic [1:0] CSR_GAIN  = 2'd0;
   localparam logic [1:0] CSR_CLOSE = 2'd1;
   localparam logic [1:0] CSR_WARN  = 2'd2;

   localparam logic [16:0] GAIN_RESET  = 17'd9830;
   localparam logic [31:0] CLOSE_RESET = 32'd5243;
   localparam logic [31:0] WARN_RESET  = 32'd19661;
   localparam logic [16:0] GAIN_ONE    = 17'd65536;

   localparam int CORDIC_STEPS = 16;
   localparam int SQRT_STEPS   = 33;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   function automatic logic signed [32:0] atan_step(input logic [3:0] idx);
      logic signed [32:0] v;
      case (idx)
         4'd0:    v = 33'sd536870912;
         4'd1:    v = 33'sd316933406;
         4'd2:    v = 33'sd167458907;
         4'd3:    v = 33'sd85004756;
         4'd4:    v = 33'sd42667331;
         4'd5:    v = 33'sd21354465;
         4'd6:    v = 33'sd10679838;
         4'd7:    v = 33'sd5340245;
         4'd8:    v = 33'sd2670163;
         4'd9:    v = 33'sd1335087;
         4'd10:   v = 33'sd667544;
         4'd11:   v = 33'sd333772;
         4'd12:   v = 33'sd166886;
         4'd13:   v = 33'sd83443;
         4'd14:   v = 33'sd41722;
         4'd15:   v = 33'sd20861;
         default: v = 33'sd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -36'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/pose_drift_correction.sv @@
// Map-frame pose correction with loop-closure drift tracking. A sample that is a clear
// command, has no valid offset, or is the first valid one after a clear or reset
// is answered in the cycle after its transfer (a clear gives no result). A corrected
// sample is worked out on one shared 33x33 multiplier (squares, EMA terms,
// rotation), a 33-step bit-pair square root of the offset step and a 16-step
// CORDIC for the smoothed yaw; no new sample is taken meanwhile.
// Registers may be written at any time the block is idle; csr_ready is always high.
`default_nettype none
module pose_drift_correction (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_command,
   input  wire logic               req_offset_valid,
   input  wire logic signed [31:0] req_offset_x,
   input  wire logic signed [31:0] req_offset_y,
   input  wire logic signed [15:0] req_offset_yaw,
   input  wire logic signed [31:0] req_pose_x,
   input  wire logic signed [31:0] req_pose_y,
   input  wire logic signed [15:0] req_pose_yaw,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_out_x,
   output logic signed [31:0]      rsp_out_y,
   output logic signed [15:0]      rsp_out_yaw,
   output logic                    rsp_passed_through,
   output logic                    rsp_closure_event,
   output logic [31:0]             rsp_drift_total,
   output logic [15:0]             rsp_closure_count,
   output logic                    rsp_drift_warning,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data
);

   pdc_pkg::state_type state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;

   logic [16:0] gain_ff;
   logic [31:0] cthr_ff, wthr_ff;

   logic signed [31:0] sx_ff, sx_in, sy_ff, sy_in, syaw_ff, syaw_in;
   logic signed [31:0] lx_ff, lx_in, ly_ff, ly_in;
   logic [31:0] drift_ff, drift_in;
   logic [15:0] count_ff, count_in;
   logic primed_ff, primed_in;

   logic signed [31:0] ox_ff, ox_in, oy_ff, oy_in, px_ff, px_in, py_ff, py_in;
   logic [15:0] oyaw_ff, oyaw_in, pyaw_ff, pyaw_in;
   logic [31:0] ax_ff, ax_in, ay_ff, ay_in;

   logic signed [65:0] acc_ff, acc_in;
   logic [35:0] rem_ff, rem_in;
   logic [32:0] root_ff, root_in;
   logic event_ff, event_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [32:0] cz_ff, cz_in;
   logic [15:0] yaw16_ff, yaw16_in;
   logic flip_ff, flip_in;
   logic signed [31:0] rx_ff, rx_in, ry_ff, ry_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] ro_x_ff, ro_x_in, ro_y_ff, ro_y_in;
   logic [15:0] ro_yaw_ff, ro_yaw_in;
   logic ro_pass_ff, ro_pass_in, ro_event_ff, ro_event_in, ro_warn_ff, ro_warn_in;
   logic [31:0] ro_drift_ff, ro_drift_in;
   logic [15:0] ro_count_ff, ro_count_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod;
   logic [16:0] g_eff, g_rest;
   logic out_busy;
   logic req_xfer;

   assign prod = mul_a * mul_b;
   assign g_eff = (gain_ff > pdc_pkg::GAIN_ONE) ? pdc_pkg::GAIN_ONE : gain_ff;
   assign g_rest = pdc_pkg::GAIN_ONE - g_eff;
   assign out_busy = rsp_valid_ff && rsp_stall;
   assign req_stall = (state_ff != pdc_pkg::ST_IDLE) || out_busy;
   assign req_xfer = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = ro_x_ff;
   assign rsp_out_y = ro_y_ff;
   assign rsp_out_yaw = ro_yaw_ff;
   assign rsp_passed_through = ro_pass_ff;
   assign rsp_closure_event = ro_event_ff;
   assign rsp_drift_total = ro_drift_ff;
   assign rsp_closure_count = ro_count_ff;
   assign rsp_drift_warning = ro_warn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pdc_pkg::ST_IDLE;
         cnt_ff <= '0;
         gain_ff <= pdc_pkg::GAIN_RESET;
         cthr_ff <= pdc_pkg::CLOSE_RESET;
         wthr_ff <= pdc_pkg::WARN_RESET;
         sx_ff <= '0;
         sy_ff <= '0;
         syaw_ff <= '0;
         lx_ff <= '0;
         ly_ff <= '0;
         drift_ff <= '0;
         count_ff <= '0;
         primed_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pdc_pkg::CSR_GAIN:  gain_ff <= csr_data[16:0];
               pdc_pkg::CSR_CLOSE: cthr_ff <= csr_data;
               pdc_pkg::CSR_WARN:  wthr_ff <= csr_data;
               default: ;
            endcase
         end
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         syaw_ff <= syaw_in;
         lx_ff <= lx_in;
         ly_ff <= ly_in;
         drift_ff <= drift_in;
         count_ff <= count_in;
         primed_ff <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ox_ff <= ox_in;
      oy_ff <= oy_in;
      px_ff <= px_in;
      py_ff <= py_in;
      oyaw_ff <= oyaw_in;
      pyaw_ff <= pyaw_in;
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      event_ff <= event_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      cz_ff <= cz_in;
      yaw16_ff <= yaw16_in;
      flip_ff <= flip_in;
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      ro_x_ff <= ro_x_in;
      ro_y_ff <= ro_y_in;
      ro_yaw_ff <= ro_yaw_in;
      ro_pass_ff <= ro_pass_in;
      ro_event_ff <= ro_event_in;
      ro_drift_ff <= ro_drift_in;
      ro_count_ff <= ro_count_in;
      ro_warn_ff <= ro_warn_in;
   end

   // shared multiplier operand select
   always_comb begin
      logic signed [33:0] cval, sval;
      cval = flip_ff ? -cx_ff : cx_ff;
      sval = flip_ff ? -cy_ff : cy_ff;
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         pdc_pkg::ST_SQ: begin
            mul_a = cnt_ff[0] ? {1'b0, ay_ff} : {1'b0, ax_ff};
            mul_b = mul_a;
         end
         pdc_pkg::ST_EMA: begin
            mul_a = cnt_ff[0] ? {16'd0, g_rest} : {16'd0, g_eff};
            case (cnt_ff[2:0])
               3'd0:    mul_b = 33'(ox_ff);
               3'd1:    mul_b = 33'(sx_ff);
               3'd2:    mul_b = 33'(oy_ff);
               3'd3:    mul_b = 33'(sy_ff);
               3'd4:    mul_b = {oyaw_ff[15], oyaw_ff, 16'd0};
               default: mul_b = 33'(syaw_ff);
            endcase
         end
         pdc_pkg::ST_ROT: begin
            mul_a = (cnt_ff[1:0] == 2'd0 || cnt_ff[1:0] == 2'd3) ? cval[32:0] : sval[32:0];
            mul_b = cnt_ff[0] ? 33'(py_ff) : 33'(px_ff);
         end
         default: ;
      endcase
   end

   always_comb begin
      logic signed [32:0] dx, dy;
      logic [35:0] cur, trial;
      logic [31:0] step;
      logic [32:0] dsum;
      logic signed [65:0] sum;
      logic [31:0] yplus;
      logic [15:0] ang;
      logic signed [33:0] xs, ys;
      logic signed [32:0] at;

      state_in = state_ff;
      cnt_in = cnt_ff;
      sx_in = sx_ff;
      sy_in = sy_ff;
      syaw_in = syaw_ff;
      lx_in = lx_ff;
      ly_in = ly_ff;
      drift_in = drift_ff;
      count_in = count_ff;
      primed_in = primed_ff;
      ox_in = ox_ff;
      oy_in = oy_ff;
      px_in = px_ff;
      py_in = py_ff;
      oyaw_in = oyaw_ff;
      pyaw_in = pyaw_ff;
      ax_in = ax_ff;
      ay_in = ay_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      event_in = event_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      yaw16_in = yaw16_ff;
      flip_in = flip_ff;
      rx_in = rx_ff;
      ry_in = ry_ff;
      rsp_valid_in = out_busy;
      ro_x_in = ro_x_ff;
      ro_y_in = ro_y_ff;
      ro_yaw_in = ro_yaw_ff;
      ro_pass_in = ro_pass_ff;
      ro_event_in = ro_event_ff;
      ro_drift_in = ro_drift_ff;
      ro_count_in = ro_count_ff;
      ro_warn_in = ro_warn_ff;

      dx = 33'(req_offset_x) - 33'(lx_ff);
      dy = 33'(req_offset_y) - 33'(ly_ff);
      cur = {rem_ff[33:0], acc_ff[65:64]};
      trial = {1'b0, root_ff, 2'b01};
      step = root_ff[32] ? 32'hffffffff : root_ff[31:0];
      dsum = {1'b0, drift_ff} + {1'b0, step};
      sum = acc_ff + prod;
      yplus = syaw_ff + 32'd32768;
      ang = '0;
      xs = cx_ff >>> cnt_ff[3:0];
      ys = cy_ff >>> cnt_ff[3:0];
      at = pdc_pkg::atan_step(cnt_ff[3:0]);

      case (state_ff)
         pdc_pkg::ST_IDLE: begin
            if (req_xfer) begin
               ox_in = req_offset_x;
               oy_in = req_offset_y;
               oyaw_in = req_offset_yaw;
               px_in = req_pose_x;
               py_in = req_pose_y;
               pyaw_in = req_pose_yaw;
               event_in = 1'b0;
               if (req_command == pdc_pkg::CMD_CLEAR) begin
                  sx_in = '0;
                  sy_in = '0;
                  syaw_in = '0;
                  lx_in = '0;
                  ly_in = '0;
                  drift_in = '0;
                  count_in = '0;
                  primed_in = 1'b0;
               end else if (req_offset_valid && primed_ff) begin
                  ax_in = dx[32] ? 32'(-dx) : dx[31:0];
                  ay_in = dy[32] ? 32'(-dy) : dy[31:0];
                  lx_in = req_offset_x;
                  ly_in = req_offset_y;
                  cnt_in = '0;
                  state_in = pdc_pkg::ST_SQ;
               end else begin
                  if (req_offset_valid) begin
                     lx_in = req_offset_x;
                     ly_in = req_offset_y;
                     primed_in = 1'b1;
                  end
                  rsp_valid_in = 1'b1;
                  ro_x_in = req_pose_x;
                  ro_y_in = req_pose_y;
                  ro_yaw_in = req_pose_yaw;
                  ro_pass_in = 1'b1;
                  ro_event_in = 1'b0;
                  ro_drift_in = drift_ff;
                  ro_count_in = count_ff;
                  ro_warn_in = drift_ff > wthr_ff;
               end
            end
         end
         pdc_pkg::ST_SQ: begin
            if (cnt_ff[0]) begin
               acc_in = sum;
               rem_in = '0;
               root_in = '0;
               cnt_in = '0;
               state_in = pdc_pkg::ST_SQRT;
            end else begin
               acc_in = prod;
               cnt_in = cnt_ff + 6'd1;
            end
         end
         pdc_pkg::ST_SQRT: begin
            // restoring square root, two radicand bits per step
            if (cur >= trial) begin
               rem_in = cur - trial;
               root_in = {root_ff[31:0], 1'b1};
            end else begin
               rem_in = cur;
               root_in = {root_ff[31:0], 1'b0};
            end
            acc_in = {acc_ff[63:0], 2'b00};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(pdc_pkg::SQRT_STEPS - 1)) begin
               state_in = pdc_pkg::ST_UPD;
            end
         end
         pdc_pkg::ST_UPD: begin
            if (step > cthr_ff) begin
               event_in = 1'b1;
               if (count_ff != 16'hffff) begin
                  count_in = count_ff + 16'd1;
               end
               drift_in = dsum[32] ? 32'hffffffff : dsum[31:0];
            end
            cnt_in = '0;
            state_in = pdc_pkg::ST_EMA;
         end
         pdc_pkg::ST_EMA: begin
            if (cnt_ff[0]) begin
               case (cnt_ff[2:1])
                  2'd0:    sx_in = sum[47:16];
                  2'd1:    sy_in = sum[47:16];
                  default: syaw_in = sum[47:16];
               endcase
            end else begin
               acc_in = prod + 66'sd32768;
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd5) begin
               state_in = pdc_pkg::ST_ANG;
            end
         end
         pdc_pkg::ST_ANG: begin
            yaw16_in = yplus[31:16];
            // fold beyond a quarter turn, negate results later
            flip_in = (yplus[31:16] > 16'h4000) && (yplus[31:16] < 16'hc000);
            ang = flip_in ? (yplus[31:16] ^ 16'h8000) : yplus[31:16];
            cz_in = {ang[15], ang, 16'd0};
            cx_in = pdc_pkg::CORDIC_GAIN;
            cy_in = '0;
            cnt_in = '0;
            state_in = pdc_pkg::ST_CORDIC;
         end
         pdc_pkg::ST_CORDIC: begin
            if (!cz_ff[32]) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - at;
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + at;
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(pdc_pkg::CORDIC_STEPS - 1)) begin
               cnt_in = '0;
               state_in = pdc_pkg::ST_ROT;
            end
         end
         pdc_pkg::ST_ROT: begin
            case (cnt_ff[1:0])
               2'd1: begin
                  sum = acc_ff - prod;
                  rx_in = pdc_pkg::sat32(36'(sx_ff) + sum[65:30]);
               end
               2'd3: begin
                  ry_in = pdc_pkg::sat32(36'(sy_ff) + sum[65:30]);
               end
               default: begin
                  acc_in = prod + 66'sd536870912;
               end
            endcase
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff[1:0] == 2'd3) begin
               state_in = pdc_pkg::ST_OUT;
            end
         end
         pdc_pkg::ST_OUT: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               ro_x_in = rx_ff;
               ro_y_in = ry_ff;
               ro_yaw_in = pyaw_ff + yaw16_ff;
               ro_pass_in = 1'b0;
               ro_event_in = event_ff;
               ro_drift_in = drift_ff;
               ro_count_in = count_ff;
               ro_warn_in = drift_ff > wthr_ff;
               state_in = pdc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pdc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire
